>>> design/deadline_ordered_alarm_queue_macros.svh
// Assertion macros shared by the alarm queue checker.
`ifndef DEADLINE_ORDERED_ALARM_QUEUE_MACROS_SVH
`define DEADLINE_ORDERED_ALARM_QUEUE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DOAQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alarm queue check failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define DOAQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alarm queue check failed: next-cycle implication");

`endif

>>> design/doaq_pkg.sv
// Types and constants of the deadline-ordered alarm queue.
package doaq_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // at most this many expiries are reported per tick
  localparam int RESULT_LIMIT = 16;
  localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [1:0] {
    ST_EXPIRED = 2'd0,
    ST_ACCEPT  = 2'd1,
    ST_REJECT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] tag;
    logic [31:0] deadline;
    logic        last;
  } result_t;

endpackage

>>> design/deadline_ordered_alarm_queue.sv
// Top level of the deadline-ordered alarm queue.
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------------------
//   in_     | in  | tuser[0] op; tdata delay_seconds, alarm_tag
//   out_    | out | tuser[1:0] status; tdata result_tag, result_deadline; tlast
//
// Add: the insert walk moves each queued entry with a later deadline up one
//   slot, reading one entry a cycle from the single read port of the store.
//   A rejected add goes straight to delivery.
// Tick: pops the expired alarms (16 at most), one store read each; a tick on
//   an empty queue leaves the input open at once.
// Reset clears the time counter and the queue pointers; no clearing pass.
// A full output register stalls the sequencer, never the store contents.
module deadline_ordered_alarm_queue import doaq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] delay_seconds, [31:16] alarm_tag
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] result_tag, [47:16] result_deadline
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic             res_valid;
  logic             out_load;
  result_t          res;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;

  logic             out_valid_r;
  result_t          out_res_r;

  doaq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser[0]),
    .in_delay    (in_tdata[15:0]),
    .in_tag      (in_tdata[31:16]),
    .res_valid   (res_valid),
    .res_ready   (out_load),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // the walk never reads the slot it writes in the same cycle
  doaq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // output register: takes a new beat when empty or being emptied
  assign out_load = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.deadline, out_res_r.tag};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

>>> design/doaq_mem.sv
// Entry store: one write port, one registered read port.
module doaq_mem import doaq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output entry_t                         rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  entry_t                         wr_data
);

  entry_t entry_mem_r [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    // data held until the next read
    if (rd_en) begin
      rd_data_r <= entry_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/doaq_ctrl.sv
// Sequencer: sorted insert walk and head pops over a circular entry store.
module doaq_ctrl import doaq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [15:0]                    in_delay,
  input  logic [15:0]                    in_tag,
  output logic                           res_valid,
  input  logic                           res_ready,
  output result_t                        res,
  output logic                           mem_rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_rd_addr,
  input  entry_t                         mem_rd_data,
  output logic                           mem_wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_wr_addr,
  output entry_t                         mem_wr_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_CMP = 6'b000010,
    S_INS_WR  = 6'b000100,
    S_ADD_OUT = 6'b001000,
    S_POP_CMP = 6'b010000,
    S_POP_END = 6'b100000
  } state_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  state_t           state_r,  state_nxt;
  logic [31:0]      now_r,    now_nxt;
  logic [IDX_W-1:0] head_r,   head_nxt;
  logic [IDX_W-1:0] tail_r,   tail_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [IDX_W-1:0] pos_r,    pos_nxt;
  logic [CNT_W-1:0] rem_r,    rem_nxt;
  logic [RES_W-1:0] n_r,      n_nxt;
  logic             pend_v_r, pend_v_nxt;
  entry_t           pend_r,   pend_nxt;
  entry_t           new_r,    new_nxt;
  status_t          add_st_r, add_st_nxt;
  logic             go;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    now_nxt     = now_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    n_nxt       = n_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    new_nxt     = new_r;
    add_st_nxt  = add_st_r;
    go          = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = head_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = pos_r;
    mem_wr_data = new_r;
    res_valid   = 1'b0;
    res         = '{status: ST_EXPIRED, tag: pend_r.tag, deadline: pend_r.deadline,
                    last: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_ADD) begin
            new_nxt = '{deadline: now_r + 32'(in_delay), tag: in_tag};
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              add_st_nxt = ST_REJECT;
              state_nxt  = S_ADD_OUT;
            end else begin
              add_st_nxt = ST_ACCEPT;
              pos_nxt    = tail_r;
              rem_nxt    = count_r;
              if (count_r == '0) begin
                state_nxt = S_INS_WR;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_prev(tail_r);
                state_nxt   = S_INS_CMP;
              end
            end
          end else begin
            now_nxt = now_r + 32'd1;
            n_nxt   = '0;
            if (count_r != '0) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = head_r;
              state_nxt   = S_POP_CMP;
            end
          end
        end
      end

      S_INS_CMP: begin
        // later deadline moves up one slot; equal stays ahead of the new one
        if (mem_rd_data.deadline > new_r.deadline) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = pos_r;
          mem_wr_data = mem_rd_data;
          pos_nxt     = idx_prev(pos_r);
          rem_nxt     = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_INS_WR;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_prev(idx_prev(pos_r));
          end
        end else begin
          mem_wr_en = 1'b1;
          count_nxt = count_r + 1'b1;
          tail_nxt  = idx_next(tail_r);
          state_nxt = S_ADD_OUT;
        end
      end

      S_INS_WR: begin
        mem_wr_en = 1'b1;
        count_nxt = count_r + 1'b1;
        tail_nxt  = idx_next(tail_r);
        state_nxt = S_ADD_OUT;
      end

      S_ADD_OUT: begin
        res_valid = 1'b1;
        res       = '{status: add_st_r, tag: new_r.tag, deadline: new_r.deadline,
                      last: 1'b1};
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_POP_CMP: begin
        if (mem_rd_data.deadline <= now_r) begin
          // previous pop goes out as not last; the read data holds on a stall
          res_valid = pend_v_r;
          go        = !pend_v_r || res_ready;
          if (go) begin
            pend_nxt   = mem_rd_data;
            pend_v_nxt = 1'b1;
            head_nxt   = idx_next(head_r);
            count_nxt  = count_r - 1'b1;
            n_nxt      = n_r + 1'b1;
            if (count_r > CNT_W'(1) && n_r < RES_W'(RESULT_LIMIT - 1)) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = idx_next(head_r);
            end else begin
              state_nxt = S_POP_END;
            end
          end
        end else begin
          state_nxt = S_POP_END;
        end
      end

      S_POP_END: begin
        if (pend_v_r) begin
          res_valid = 1'b1;
          res.last  = 1'b1;
          if (res_ready) begin
            pend_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      now_r    <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    rem_r    <= rem_nxt;
    n_r      <= n_nxt;
    pend_r   <= pend_nxt;
    new_r    <= new_nxt;
    add_st_r <= add_st_nxt;
  end

endmodule

>>> design/doaq_chk.sv
// Port-level checker for the alarm queue, bound to the top level.
`include "deadline_ordered_alarm_queue_macros.svh"

module doaq_chk import doaq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  logic        out_stall;
  logic [50:0] out_beat;
  logic        out_add_beat;
  logic        in_add_beat;

  assign out_stall    = out_tvalid && !out_tready;
  assign out_beat     = {out_tlast, out_tuser, out_tdata};
  assign out_add_beat = out_tvalid && (out_tuser inside {ST_ACCEPT, ST_REJECT});
  assign in_add_beat  = in_tvalid && in_tready && (in_tuser[0] == OP_ADD);

  // a stalled result beat holds
  `DOAQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_beat))

  // an add answers with exactly one beat, so it is always the last
  `DOAQ_ASSERT_IMP(a_add_last, clk, rst_n, out_add_beat, out_tlast)

  // an accepted add keeps the input closed for at least the next cycle
  `DOAQ_ASSERT_NXT(a_add_busy, clk, rst_n, in_add_beat, !in_tready)

endmodule

bind deadline_ordered_alarm_queue doaq_chk u_doaq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> tb/tb_deadline_ordered_alarm_queue.sv
// Self-checking testbench for the deadline-ordered alarm queue, with a scoreboard and random idling.
module tb_deadline_ordered_alarm_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import doaq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  // Watchdog limit, several times the slowest sensible run.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles after the last result before the block is taken as settled:
  // an idle tick still walks the head, an add may walk the whole queue.
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 4;
  localparam int IDLE_PERCENT = 38;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] delay_seconds, [31:16] alarm_tag
  logic [0:0]  in_tuser = '0;   // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [15:0] result_tag, [47:16] result_deadline
  logic [1:0]  out_tuser;       // [1:0] status
  logic        out_tlast;

  // Predictor state: time counter and the sorted alarm list.
  logic [31:0] alarm_clock;
  entry_t      alarm_list[$];
  // Results the block still owes, oldest first.
  result_t     owed_results[$];

  int mismatches = 0;
  int cycle_count = 0;

  // Idling control shared between the stimulus and the receiver.
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  int hold_seq = 0;        // bumped by a test to request a long hold-off
  int hold_len = 0;
  int hold_seen = 0;       // owned by the receiver
  int hold_left = 0;       // owned by the receiver

  deadline_ordered_alarm_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random ready, steady ready, or a long hold-off counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_left  <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (out_steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Result checker: every accepted beat against the oldest owed result.
  always @(posedge clk) begin
    result_t owed;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat: status %0d tag %h deadline %h",
                                  out_tuser, out_tdata[15:0], out_tdata[47:16]));
      end else begin
        owed = owed_results.pop_front();
        if (out_tuser != owed.status)
          report_mismatch($sformatf("status: got %0d, want %0d", out_tuser, owed.status));
        if (out_tdata[15:0] != owed.tag)
          report_mismatch($sformatf("tag: got %h, want %h", out_tdata[15:0], owed.tag));
        if (out_tdata[47:16] != owed.deadline)
          report_mismatch($sformatf("deadline: got %h, want %h", out_tdata[47:16],
                                    owed.deadline));
        if (out_tlast != owed.last)
          report_mismatch($sformatf("last: got %b, want %b", out_tlast, owed.last));
      end
    end
  end

  // Works out what one accepted input beat must produce.
  task automatic predict_alarm_results(input logic op, input logic [15:0] delay,
                                       input logic [15:0] tag);
    logic [31:0] deadline;
    int          pos;
    int          popped;
    result_t     res;
    bit          held;
    entry_t      ent;
    if (op == OP_ADD) begin
      deadline = alarm_clock + {16'h0000, delay};
      res = '{status: ST_ACCEPT, tag: tag, deadline: deadline, last: 1'b1};
      if (alarm_list.size() >= QUEUE_DEPTH) begin
        res.status = ST_REJECT;
      end else begin
        // equal deadlines go behind the existing ones
        pos = 0;
        while (pos < alarm_list.size() && alarm_list[pos].deadline <= deadline) pos++;
        ent = '{deadline: deadline, tag: tag};
        alarm_list.insert(pos, ent);
      end
      owed_results.push_back(res);
    end else begin
      alarm_clock = alarm_clock + 32'd1;
      popped = 0;
      held = 1'b0;
      while (popped < RESULT_LIMIT && alarm_list.size() != 0 &&
             alarm_list[0].deadline <= alarm_clock) begin
        if (held) owed_results.push_back(res);
        ent = alarm_list.pop_front();
        res = '{status: ST_EXPIRED, tag: ent.tag, deadline: ent.deadline, last: 1'b0};
        held = 1'b1;
        popped++;
      end
      // final expiry of the tick carries the last mark
      if (held) begin
        res.last = 1'b1;
        owed_results.push_back(res);
      end
    end
  endtask

  // Offers one beat, with random idle cycles first, and returns on acceptance.
  // tvalid is left high so a following beat can go back to back.
  task automatic send_item(input logic op, input logic [15:0] delay, input logic [15:0] tag);
    int gap;
    gap = 0;
    if (!in_steady)
      while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {tag, delay};
    do @(posedge clk); while (!in_tready);
    predict_alarm_results(op, delay, tag);
  endtask

  // Drops tvalid, waits for every owed result and lets the block go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] any_tag();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Tick on an empty queue: no result at all.
  task automatic test_idle_tick();
    send_item(OP_TICK, any_tag(), any_tag());
    settle();
  endtask

  // Equal deadlines reached by different add times leave in arrival order.
  task automatic test_equal_deadlines();
    send_item(OP_ADD, 16'd2, 16'h1111);
    send_item(OP_ADD, 16'd1, 16'h2222);
    send_item(OP_TICK, any_tag(), any_tag());
    send_item(OP_ADD, 16'd1, 16'h3333);   // same deadline as the first alarm
    send_item(OP_TICK, any_tag(), any_tag());
    settle();
  endtask

  // Fill to capacity with zero and one second delays, overflow once with the
  // largest delay, then one tick expires the whole queue in a single burst.
  task automatic test_full_queue_burst();
    logic [15:0] tag;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      tag = (i == 0) ? 16'h0000 : (i == QUEUE_DEPTH - 1) ? 16'hFFFF : any_tag();
      send_item(OP_ADD, 16'(i % 2), tag);
    end
    send_item(OP_ADD, 16'hFFFF, any_tag());
    send_item(OP_TICK, any_tag(), any_tag());
    settle();
  endtask

  // Receiver stalls for a long stretch while beats keep coming, so the
  // output register fills and the block holds off its input.
  task automatic test_output_backpressure();
    hold_len = 300;
    hold_seq++;
    for (int i = 0; i < 20; i++) begin
      if (i % 5 == 4) send_item(OP_TICK, any_tag(), any_tag());
      else send_item(OP_ADD, 16'($urandom_range(0, 3)), any_tag());
    end
    settle();
  endtask

  // Mixed adds and ticks with short delays so the queue churns and now and
  // then fills; a middle stretch runs with no idling on either side.
  task automatic test_random_traffic();
    for (int i = 0; i < 300; i++) begin
      in_steady  = (i >= 140 && i < 220);
      out_steady = in_steady;
      if ($urandom_range(0, 99) < 55)
        send_item(OP_ADD, 16'($urandom_range(0, 20)), any_tag());
      else
        send_item(OP_TICK, any_tag(), any_tag());
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
    settle();
  endtask

  // Full-range delays; these alarms stay queued, so this runs last and
  // ends up rejecting once the queue is full.
  task automatic test_long_delays();
    for (int i = 0; i < 20; i++)
      send_item(OP_ADD, (i == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF)), any_tag());
    send_item(OP_TICK, any_tag(), any_tag());
    send_item(OP_TICK, any_tag(), any_tag());
    settle();
  endtask

  initial begin
    alarm_clock = '0;
    alarm_list.delete();
    owed_results.delete();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_tick();
    test_equal_deadlines();
    test_full_queue_burst();
    test_output_backpressure();
    test_random_traffic();
    test_long_delays();

    if (owed_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
